>>> hdl/queue_with_remove_by_value_assert.svh
// Assertion macros for the queue_with_remove_by_value checker.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef QUEUE_WITH_REMOVE_BY_VALUE_ASSERT_SVH
`define QUEUE_WITH_REMOVE_BY_VALUE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define QRV_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define QRV_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/qrv_pkg.sv
// Package for the queue with remove-by-value: word types, op and status codes.
// No dependencies.
`timescale 1ns / 1ps

package qrv_pkg;

	localparam int CAPACITY = 64;
	localparam int DATA_W   = 32;
	localparam int FUNC_W   = 3;
	localparam int STAT_W   = 2;
	localparam int COUNT_W  = 7;

	// operation codes
	localparam logic [FUNC_W-1:0] FN_PUSH   = 3'd0;
	localparam logic [FUNC_W-1:0] FN_POP    = 3'd1;
	localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd2;
	localparam logic [FUNC_W-1:0] FN_SEARCH = 3'd3;
	localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd4;

	// status codes
	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;
	localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

	localparam logic signed [DATA_W-1:0] HEAD_NONE = '1;

	typedef struct packed {
		logic [FUNC_W-1:0]        func;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0]        status;
		logic                     found;
		logic signed [DATA_W-1:0] head_value;
		logic [COUNT_W-1:0]       count;
		logic                     is_empty;
	} rsp_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_RUN
	} fsm_t;

endpackage

>>> hdl/queue_with_remove_by_value.sv
// Top level of the queue with remove-by-value: entry RAM, scan/shift sequencer.
// Depends on qrv_pkg.
`timescale 1ns / 1ps

// Usage
//  Command channel: drive req and raise start; the word is taken at a clock
//  edge where start is high and busy is low. busy stays high while a pop,
//  remove or search walks the entry RAM.
//  Result channel: done pulses for one cycle with rsp valid. There is no
//  back-pressure: the receiver must take the word in that cycle.
//  Push, clear, unused codes and pop on an empty queue are answered from idle
//  without a walk. Pop, remove and search walk the entry RAM: a pop shifts
//  entries 1 to count - 1 down, remove and search read from entry 0, and a
//  search stops at its first hit. busy is low again in the cycle done is
//  high, so the next word can be taken then. The walk is paced by the single
//  read port of the entry RAM: one entry is read per cycle, and the shift
//  that closes a gap writes one entry behind the read, so the walk is
//  pipelined one deep.
//  Reset: count clears, the RAM is left as is (entries above count are never
//  read). No clearing pass is needed; the block takes a command right after
//  reset.
module queue_with_remove_by_value
	import qrv_pkg::*;
#(
	parameter int CAPACITY = qrv_pkg::CAPACITY
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic done,
	output rsp_t rsp
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	// sequencer state
	fsm_t           state_q, state_d;
	logic [CW-1:0]  count_q, count_d;
	logic [CW-1:0]  rd_ptr_q, rd_ptr_d;     // next entry to read
	logic           hit_q, hit_d;           // gap is open, shifting down
	logic [DATA_W-1:0] head_q, head_d;      // copy of entry 0
	logic [FUNC_W-1:0] func_q;
	logic [DATA_W-1:0] value_q;

	// entry RAM, one write and one read port, registered read
	logic [DATA_W-1:0] mem [CAPACITY];
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [DATA_W-1:0] mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [DATA_W-1:0] rdata_s1;
	logic [AW-1:0]     rd_idx_s1;
	logic              rd_vld_s1;

	// result
	logic              fin;
	logic [STAT_W-1:0] fin_status;
	logic              fin_found;
	logic              accept;
	logic              done_q;
	rsp_t              rsp_q;

	assign busy   = (state_q != FSM_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;
	assign rsp    = rsp_q;

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		rd_ptr_d   = rd_ptr_q;
		hit_d      = hit_q;
		head_d     = head_q;
		mem_we     = 1'b0;
		mem_waddr  = count_q[AW-1:0];
		mem_wdata  = req.value;
		mem_re     = 1'b0;
		mem_raddr  = rd_ptr_q[AW-1:0];
		fin        = 1'b0;
		fin_status = STAT_OK;
		fin_found  = 1'b0;

		unique case (state_q)
			FSM_IDLE: begin
				if (start) begin
					unique case (req.func) inside
						FN_PUSH: begin
							fin = 1'b1;
							if (count_q == CW'(CAPACITY)) begin
								fin_status = STAT_FULL;
							end else begin
								mem_we  = 1'b1;
								count_d = count_q + CW'(1);
								if (count_q == '0) begin
									head_d = req.value;
								end
							end
						end
						FN_POP: begin
							if (count_q == '0) begin
								fin        = 1'b1;
								fin_status = STAT_EMPTY;
							end else begin
								// gap at entry 0, shift starts with entry 1
								state_d  = FSM_RUN;
								hit_d    = 1'b1;
								rd_ptr_d = CW'(1);
							end
						end
						FN_REMOVE, FN_SEARCH: begin
							state_d  = FSM_RUN;
							hit_d    = 1'b0;
							rd_ptr_d = '0;
						end
						FN_CLEAR: begin
							fin     = 1'b1;
							count_d = '0;
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			FSM_RUN: begin
				if (rd_ptr_q < count_q) begin
					mem_re   = 1'b1;
					rd_ptr_d = rd_ptr_q + CW'(1);
				end
				if (rd_vld_s1) begin
					if (hit_q) begin
						// move entry down into the gap just behind it
						mem_we    = 1'b1;
						mem_waddr = rd_idx_s1 - AW'(1);
						mem_wdata = rdata_s1;
						if (rd_idx_s1 == AW'(1)) begin
							head_d = rdata_s1;
						end
					end else if (rdata_s1 == value_q) begin
						if (func_q == FN_SEARCH) begin
							fin       = 1'b1;
							fin_found = 1'b1;
							state_d   = FSM_IDLE;
						end else begin
							hit_d = 1'b1;
						end
					end
				end else if (rd_ptr_q == count_q) begin
					// walk drained
					fin     = 1'b1;
					state_d = FSM_IDLE;
					if (hit_q) begin
						count_d   = count_q - CW'(1);
						fin_found = (func_q != FN_POP);
					end else begin
						fin_status = STAT_NOTFOUND;
					end
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= FSM_IDLE;
			count_q   <= '0;
			rd_ptr_q  <= '0;
			hit_q     <= 1'b0;
			rd_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			rd_ptr_q  <= rd_ptr_d;
			hit_q     <= hit_d;
			rd_vld_s1 <= mem_re;
			done_q    <= fin;
		end
	end

	always_ff @(posedge clk) begin
		head_q <= head_d;
		if (accept) begin
			func_q  <= req.func;
			value_q <= req.value;
		end
		if (fin) begin
			rsp_q.status     <= fin_status;
			rsp_q.found      <= fin_found;
			rsp_q.head_value <= (count_d == '0) ? HEAD_NONE : head_d;
			rsp_q.count      <= COUNT_W'(count_d);
			rsp_q.is_empty   <= (count_d == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_s1  <= mem[mem_raddr];
			rd_idx_s1 <= mem_raddr;
		end
	end

endmodule

>>> hdl/qrv_chk.sv
// Port-level checker for queue_with_remove_by_value, bound to the top level.
// Depends on qrv_pkg and queue_with_remove_by_value_assert.svh.
`timescale 1ns / 1ps
`include "queue_with_remove_by_value_assert.svh"

module qrv_chk
	import qrv_pkg::*;
#(
	parameter int CAPACITY = qrv_pkg::CAPACITY
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input req_t req,
	input logic busy,
	input logic done,
	input rsp_t rsp
);

	`QRV_ASSERT_NOW(a_empty_flag, done, rsp.is_empty == (rsp.count == '0), "empty flag vs count")
	`QRV_ASSERT_NOW(a_empty_head, done && rsp.is_empty, rsp.head_value == HEAD_NONE, "bad head")
	`QRV_ASSERT_NXT(a_word_taken, start && !busy, busy || done, "accepted word dropped")
	`QRV_ASSERT_NOW(a_done_cause, done, $past(start && !busy) || $past(busy), "stray result")
	`QRV_ASSERT_NOW(a_count_cap, done, rsp.count <= CAPACITY, "count above capacity")

endmodule

bind queue_with_remove_by_value qrv_chk #(.CAPACITY(CAPACITY)) u_qrv_chk (.*);

>>> sim/tb_queue_with_remove_by_value.sv
// Self-checking bench for queue_with_remove_by_value: directed and random commands,
// with every result checked against a shadow queue. Depends on qrv_pkg and the RTL.
`timescale 1ns / 1ps

module tb_queue_with_remove_by_value;
	import qrv_pkg::*;

	localparam int WORDS_TOTAL    = 850;
	localparam int WATCHDOG_LIMIT = 4000;  // idle cycles, far beyond one full scan
	localparam int SETTLE_CYCLES  = 80;

	localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

	// Shadow of the queue contents plus the words the block still owes us.
	class queue_tracker;
		logic signed [DATA_W-1:0] held[$];
		rsp_t awaited[$];
		int mismatches;

		function new();
			mismatches = 0;
		endfunction

		function int depth();
			return held.size();
		endfunction

		function int outstanding();
			return awaited.size();
		endfunction

		// A value currently in the queue, so removes and searches hit.
		function logic signed [DATA_W-1:0] held_value();
			if (held.size() == 0) begin
				return '0;
			end
			return held[$urandom_range(0, held.size() - 1)];
		endfunction

		// Apply one accepted command to the shadow and queue up its result.
		function void note_command(req_t cmd);
			rsp_t w;
			int hit;
			w = '0;
			hit = -1;
			if (cmd.func == FN_REMOVE || cmd.func == FN_SEARCH) begin
				for (int i = 0; i < held.size(); i++) begin
					if (hit < 0 && held[i] == cmd.value) begin
						hit = i;
					end
				end
			end
			case (cmd.func)
				FN_PUSH: begin
					if (held.size() >= CAPACITY) begin
						w.status = STAT_FULL;
					end else begin
						held.push_back(cmd.value);
					end
				end
				FN_POP: begin
					if (held.size() == 0) begin
						w.status = STAT_EMPTY;
					end else begin
						void'(held.pop_front());
					end
				end
				FN_REMOVE: begin
					if (hit >= 0) begin
						held.delete(hit);
						w.found = 1'b1;
					end else begin
						w.status = STAT_NOTFOUND;
					end
				end
				FN_SEARCH: begin
					if (hit >= 0) begin
						w.found = 1'b1;
					end else begin
						w.status = STAT_NOTFOUND;
					end
				end
				FN_CLEAR: begin
					held.delete();
				end
				default: begin
				end
			endcase
			w.head_value = (held.size() == 0) ? HEAD_NONE : held[0];
			w.count      = COUNT_W'(held.size());
			w.is_empty   = (held.size() == 0);
			awaited.push_back(w);
		endfunction

		task report(string msg);
			mismatches++;
			$display("MISMATCH @%0t: %s", $realtime, msg);
		endtask

		task check_response(rsp_t got);
			rsp_t want;
			if (awaited.size() == 0) begin
				report($sformatf("result word with nothing pending: %p", got));
				return;
			end
			want = awaited.pop_front();
			if (got.status !== want.status || got.found !== want.found ||
					got.head_value !== want.head_value || got.count !== want.count ||
					got.is_empty !== want.is_empty) begin
				report($sformatf(
					"status %0d/%0d found %0b/%0b head %0d/%0d count %0d/%0d empty %0b/%0b",
					got.status, want.status, got.found, want.found,
					got.head_value, want.head_value, got.count, want.count,
					got.is_empty, want.is_empty));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic start;
	req_t req;
	logic busy;
	logic done;
	rsp_t rsp;

	queue_tracker tracker;
	int words_sent;
	bit burst_mode;   // while set, commands go back to back
	int idle_run;

	queue_with_remove_by_value dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.req   (req),
		.busy  (busy),
		.done  (done),
		.rsp   (rsp)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Result side: done is a one-cycle strobe, no back-pressure, so every
	// sampled strobe is a word that must match the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && done) begin
			tracker.check_response(rsp);
		end
	end

	// Watchdog: any handshake on either side restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_run <= 0;
		end else if (idle_run >= WATCHDOG_LIMIT) begin
			$display("watchdog: no activity for %0d cycles", WATCHDOG_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end else begin
			idle_run <= idle_run + 1;
		end
	end

	// Drive one command word at the falling edge and hold it until the block
	// takes it (start high, busy low at a rising edge). A zero gap leaves
	// start high so the next word follows without a bubble.
	task automatic send_command(input logic [FUNC_W-1:0] f, input logic signed [DATA_W-1:0] v);
		req_t w;
		int gap;
		w.func  = f;
		w.value = v;
		@(negedge clk);
		start <= 1'b1;
		req   <= w;
		do @(posedge clk); while (busy !== 1'b0);
		tracker.note_command(w);
		words_sent++;
		gap = burst_mode ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Hold off the command side until every owed result word has arrived.
	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (tracker.outstanding() != 0) @(posedge clk);
	endtask

	// Mostly a small pool so values repeat and removes/searches find
	// duplicates; extremes and full-range values mixed in.
	function automatic logic signed [DATA_W-1:0] pool_value();
		int r;
		r = $urandom_range(0, 9);
		if (r <= 5) begin
			return $urandom_range(0, 11) - 4;
		end else if (r == 6) begin
			return VAL_MIN;
		end else if (r == 7) begin
			return VAL_MAX;
		end
		return $urandom;
	endfunction

	// Push until the queue is full, then push twice more into the full queue
	// and probe the tail end where the scans run longest.
	task automatic fill_to_capacity();
		while (tracker.depth() < CAPACITY) begin
			send_command(FN_PUSH, pool_value());
		end
		send_command(FN_PUSH, pool_value());
		send_command(FN_PUSH, VAL_MAX);
		send_command(FN_SEARCH, tracker.held[CAPACITY-1]);
		send_command(FN_REMOVE, tracker.held[tracker.depth()-1]);
	endtask

	task automatic random_command();
		int r;
		r = $urandom_range(0, 99);
		if (r < 42) begin
			send_command(FN_PUSH, pool_value());
		end else if (r < 55) begin
			send_command(FN_POP, $urandom);
		end else if (r < 75) begin
			send_command(FN_REMOVE,
				($urandom_range(0, 9) < 7) ? tracker.held_value() : pool_value());
		end else if (r < 92) begin
			send_command(FN_SEARCH,
				($urandom_range(0, 9) < 6) ? tracker.held_value() : pool_value());
		end else if (r < 94) begin
			send_command(FN_CLEAR, $urandom);
		end else begin
			// codes 5..7 do nothing but still answer
			send_command(FUNC_W'($urandom_range(5, 7)), $urandom);
		end
	endtask

	initial begin
		int pick;
		clk        = 1'b0;
		arst_n     = 1'b0;
		start      = 1'b0;
		req        = '0;
		words_sent = 0;
		burst_mode = 1'b0;
		idle_run   = 0;
		tracker    = new();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: corner cases on an empty and a short queue
		send_command(FN_POP, 0);               // pop when empty
		send_command(FN_REMOVE, 7);            // remove on empty queue
		send_command(FN_SEARCH, 0);            // search on empty queue
		send_command(FN_PUSH, 7);
		send_command(FN_REMOVE, 7);            // remove the only entry
		send_command(FN_PUSH, VAL_MAX);
		send_command(FN_PUSH, VAL_MIN);
		send_command(FN_PUSH, -1);             // looks like the empty head marker
		send_command(FN_PUSH, 0);
		send_command(FN_PUSH, 0);              // duplicate
		send_command(FN_PUSH, 5);
		send_command(FN_SEARCH, 0);            // hit
		send_command(FN_SEARCH, 99);           // miss
		send_command(FN_REMOVE, 0);            // first of two equal entries
		send_command(FN_REMOVE, -1);           // middle
		send_command(FN_REMOVE, 5);            // tail
		send_command(FN_REMOVE, VAL_MAX);      // head
		send_command(FN_REMOVE, 42);           // miss on a non-empty queue
		send_command(3'd5, 1);
		send_command(3'd6, VAL_MIN);
		send_command(3'd7, VAL_MAX);
		send_command(FN_POP, 0);
		send_command(FN_PUSH, 3);
		send_command(FN_CLEAR, 0);
		send_command(FN_POP, 0);
		drain_results();

		// full queue once up front, then random traffic with more fills and
		// drain pauses scattered through it
		fill_to_capacity();
		while (words_sent < WORDS_TOTAL) begin
			if ($urandom_range(0, 39) == 0) begin
				burst_mode = !burst_mode;
			end
			pick = $urandom_range(0, 199);
			if (pick == 0) begin
				fill_to_capacity();
			end else if (pick == 1) begin
				drain_results();
			end else begin
				random_command();
			end
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

>>> filelist.f
+incdir+hdl
hdl/qrv_pkg.sv
hdl/queue_with_remove_by_value.sv
hdl/qrv_chk.sv
sim/tb_queue_with_remove_by_value.sv
